>>> rtl/smcs_pkg.sv
// Shared types and codes for the serial memory card slave.
// Used by the front decoder, the command queue and the back end.
`default_nettype none

package smcs_pkg;

  // op codes as they arrive on the input channel
  localparam logic [2:0] OP_START_WR  = 3'd0;
  localparam logic [2:0] OP_START_RD  = 3'd1;
  localparam logic [2:0] OP_RECV      = 3'd2;
  localparam logic [2:0] OP_XMIT      = 3'd3;
  localparam logic [2:0] OP_REWIND    = 3'd4;
  localparam logic [2:0] OP_STOP      = 3'd5;
  localparam logic [2:0] OP_CLR_DIRTY = 3'd6;

  // configuration register indexes
  localparam logic CFG_ATTACHED  = 1'b0;
  localparam logic CFG_SIZE_LOG2 = 1'b1;

  localparam logic [4:0] SIZE_LOG2_RESET = 5'd16;
  localparam logic [4:0] SIZE_LOG2_MIN   = 5'd2;
  localparam logic [7:0] DETACHED_BYTE   = 8'hFF;
  localparam int unsigned PTR_W = 16;

  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_START_WR,
    CMD_START_RD,
    CMD_RECV,
    CMD_XMIT,
    CMD_REWIND,
    CMD_STOP,
    CMD_CLR_DIRTY
  } cmd_e;

  typedef struct packed {
    cmd_e       kind;
    logic [7:0] data;
  } cmd_t;

  typedef enum logic [1:0] {
    TXN_IDLE,
    TXN_WRITE,
    TXN_READ
  } txn_e;

  typedef enum logic [1:0] {
    PH_HIGH,
    PH_LOW,
    PH_DATA
  } phase_e;

  typedef enum logic {
    BK_IDLE,
    BK_EXEC
  } back_state_e;

endpackage

`default_nettype wire

>>> rtl/smcs_queue.sv
// Two-entry command queue between the front decoder and the back end.
// Depends on smcs_pkg for the command word type.
`default_nettype none

module smcs_queue (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             push_i,
  input  smcs_pkg::cmd_t  push_cmd_i,
  output logic            full_o,
  input  wire             pop_i,
  output smcs_pkg::cmd_t  pop_cmd_o,
  output logic            empty_o
);
  import smcs_pkg::*;

  cmd_t       entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign full_o    = (count_q == 2'd2);
  assign empty_o   = (count_q == 2'd0);
  assign pop_cmd_o = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/smcs_front.sv
// Input side: takes words off the input channel and turns op codes into commands.
// Depends on smcs_pkg; feeds smcs_queue.
`default_nettype none

module smcs_front (
  input  wire             in_valid_i,
  output logic            in_stall_o,
  input  wire  [2:0]      op_i,
  input  wire  [7:0]      data_in_i,
  input  wire             q_full_i,
  output logic            push_o,
  output smcs_pkg::cmd_t  push_cmd_o
);
  import smcs_pkg::*;

  cmd_e kind;

  always_comb begin
    unique case (op_i)
      OP_START_WR:  kind = CMD_START_WR;
      OP_START_RD:  kind = CMD_START_RD;
      OP_RECV:      kind = CMD_RECV;
      OP_XMIT:      kind = CMD_XMIT;
      OP_REWIND:    kind = CMD_REWIND;
      OP_STOP:      kind = CMD_STOP;
      OP_CLR_DIRTY: kind = CMD_CLR_DIRTY;
      default:      kind = CMD_NOP;
    endcase
  end

  assign in_stall_o      = q_full_i;
  assign push_o          = in_valid_i && !q_full_i;
  assign push_cmd_o.kind = kind;
  assign push_cmd_o.data = data_in_i;

endmodule

`default_nettype wire

>>> rtl/smcs_back.sv
// Back end: card memory, pointer/transaction state, statistics and result word.
// Depends on smcs_pkg; pulls commands from smcs_queue.
`default_nettype none

module smcs_back #(
  parameter int unsigned ADDR_BITS = 16
) (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             cfg_we_i,
  input  wire             cfg_idx_i,
  input  wire  [4:0]      cfg_data_i,
  input  wire             q_empty_i,
  input  smcs_pkg::cmd_t  q_cmd_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  wire             out_stall_i,
  output logic [7:0]      read_data_o,
  output logic            dirty_flag_o,
  output logic [15:0]     pointer_now_o,
  output logic [31:0]     read_txn_count_o,
  output logic [31:0]     write_txn_count_o,
  output logic [31:0]     bytes_written_count_o,
  output logic [31:0]     bytes_read_count_o
);
  import smcs_pkg::*;

  localparam int unsigned MEM_DEPTH = 1 << ADDR_BITS;
  localparam logic [4:0]  LG_MAX    = 5'(ADDR_BITS);

  logic [7:0] mem [MEM_DEPTH];
  logic [7:0] rd_q;

  back_state_e state_q, state_d;
  cmd_t        cmd_q;
  logic        exec;

  logic        attached_q;
  logic [4:0]  size_log2_q;

  logic [15:0] ptr_q, ptr_d;
  logic [7:0]  staged_q, staged_d;
  txn_e        txn_q, txn_d;
  phase_e      phase_q, phase_d;
  logic        dirty_q, dirty_d;
  logic [31:0] rd_txn_q, rd_txn_d;
  logic [31:0] wr_txn_q, wr_txn_d;
  logic [31:0] bw_q, bw_d;
  logic [31:0] br_q, br_d;
  logic [7:0]  rdata_q, rdata_d;
  logic        out_valid_q, out_valid_d;
  logic        mem_we;

  logic [4:0]  lg;
  logic [15:0] mask;
  logic [15:0] close_ptr;

  // size clamp and pointer mask; zero when detached
  always_comb begin
    if (size_log2_q < SIZE_LOG2_MIN) begin
      lg = SIZE_LOG2_MIN;
    end else if (size_log2_q > LG_MAX) begin
      lg = LG_MAX;
    end else begin
      lg = size_log2_q;
    end
    for (int i = 0; i < 16; i++) begin
      mask[i] = attached_q && (5'(i) < lg);
    end
  end

  assign close_ptr = {staged_q, 8'h00} & mask;

  // sequencer: issue a command (memory read), then execute it
  always_comb begin
    state_d = state_q;
    pop_o   = 1'b0;
    exec    = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        if (!q_empty_i && (!out_valid_q || !out_stall_i)) begin
          pop_o   = 1'b1;
          state_d = BK_EXEC;
        end
      end
      BK_EXEC: begin
        exec    = 1'b1;
        state_d = BK_IDLE;
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    ptr_d       = ptr_q;
    staged_d    = staged_q;
    txn_d       = txn_q;
    phase_d     = phase_q;
    dirty_d     = dirty_q;
    rd_txn_d    = rd_txn_q;
    wr_txn_d    = wr_txn_q;
    bw_d        = bw_q;
    br_d        = br_q;
    rdata_d     = rdata_q;
    out_valid_d = out_valid_q;
    mem_we      = 1'b0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    if (exec) begin
      out_valid_d = 1'b1;
      rdata_d     = 8'h00;
      unique case (cmd_q.kind)
        CMD_START_WR, CMD_START_RD: begin
          // an open write that only got the high byte commits it
          if (txn_q == TXN_WRITE && phase_q == PH_LOW) begin
            ptr_d = close_ptr;
          end
          phase_d = PH_HIGH;
          if (cmd_q.kind == CMD_START_RD) begin
            txn_d    = TXN_READ;
            rd_txn_d = rd_txn_q + 32'd1;
          end else begin
            txn_d    = TXN_WRITE;
            wr_txn_d = wr_txn_q + 32'd1;
          end
        end
        CMD_RECV: begin
          if (txn_q == TXN_WRITE) begin
            unique case (phase_q)
              PH_HIGH: begin
                staged_d = cmd_q.data;
                phase_d  = PH_LOW;
              end
              PH_LOW: begin
                ptr_d   = {staged_q, cmd_q.data} & mask;
                phase_d = PH_DATA;
              end
              PH_DATA: begin
                if (attached_q) begin
                  mem_we  = 1'b1;
                  ptr_d   = (ptr_q + 16'd1) & mask;
                  dirty_d = 1'b1;
                  bw_d    = bw_q + 32'd1;
                end
              end
              default: ;
            endcase
          end
        end
        CMD_XMIT: begin
          if (!attached_q) begin
            rdata_d = DETACHED_BYTE;
          end else begin
            rdata_d = rd_q;
            ptr_d   = (ptr_q + 16'd1) & mask;
            br_d    = br_q + 32'd1;
          end
        end
        CMD_REWIND: begin
          if (attached_q) begin
            ptr_d = (ptr_q - 16'd1) & mask;
            if (br_q != 32'd0) begin
              br_d = br_q - 32'd1;
            end
          end
        end
        CMD_STOP: begin
          if (txn_q == TXN_WRITE && phase_q == PH_LOW) begin
            ptr_d = close_ptr;
          end
          txn_d   = TXN_IDLE;
          phase_d = PH_HIGH;
        end
        CMD_CLR_DIRTY: dirty_d = 1'b0;
        CMD_NOP: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      attached_q  <= 1'b0;
      size_log2_q <= SIZE_LOG2_RESET;
      ptr_q       <= 16'd0;
      staged_q    <= 8'd0;
      txn_q       <= TXN_IDLE;
      phase_q     <= PH_HIGH;
      dirty_q     <= 1'b0;
      rd_txn_q    <= 32'd0;
      wr_txn_q    <= 32'd0;
      bw_q        <= 32'd0;
      br_q        <= 32'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      staged_q    <= staged_d;
      txn_q       <= txn_d;
      phase_q     <= phase_d;
      dirty_q     <= dirty_d;
      rd_txn_q    <= rd_txn_d;
      wr_txn_q    <= wr_txn_d;
      bw_q        <= bw_d;
      br_q        <= br_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_ATTACHED:  attached_q  <= cfg_data_i[0];
          CFG_SIZE_LOG2: size_log2_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    rdata_q <= rdata_d;
    if (pop_o) begin
      cmd_q <= q_cmd_i;
    end
  end

  // card memory: read at issue, written at execute
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      rd_q <= mem[ptr_q[ADDR_BITS-1:0]];
    end
    if (mem_we) begin
      mem[ptr_q[ADDR_BITS-1:0]] <= cmd_q.data;
    end
  end

  // state only moves after the previous result word has left
  assign out_valid_o           = out_valid_q;
  assign read_data_o           = rdata_q;
  assign dirty_flag_o          = dirty_q;
  assign pointer_now_o         = ptr_q;
  assign read_txn_count_o      = rd_txn_q;
  assign write_txn_count_o     = wr_txn_q;
  assign bytes_written_count_o = bw_q;
  assign bytes_read_count_o    = br_q;

endmodule

`default_nettype wire

>>> rtl/serial_memory_card_slave.sv
// Top level of the serial memory card slave: front decoder, command queue, back end.
// Depends on smcs_pkg, smcs_front, smcs_queue and smcs_back.
//
//  channel | handshake                    | payload
//  --------+------------------------------+-------------------------------------------
//  in      | in_valid_i / in_stall_o      | op_i, data_in_i
//  out     | out_valid_o / out_stall_i    | read_data_o, dirty_flag_o, pointer_now_o,
//          |                              | read_txn_count_o, write_txn_count_o,
//          |                              | bytes_written_count_o, bytes_read_count_o
//  cfg     | cfg_we_i (no wait)           | cfg_idx_i, cfg_data_i
//
//  Each word passes through the back end in an issue step, which starts the registered
//  card memory read at the current pointer, and an execute step, which loads the result word.
//  A two-entry queue lets the input side accept words while the back end works.
//  The back end issues the next word only once the result word is free or taken.
//  Reset is asynchronous; no memory clearing pass, the card memory holds garbage
//  until written.
`default_nettype none

module serial_memory_card_slave #(
  parameter int unsigned ADDR_BITS = 16
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_we_i,
  input  wire         cfg_idx_i,
  input  wire  [4:0]  cfg_data_i,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire  [2:0]  op_i,
  input  wire  [7:0]  data_in_i,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic [7:0]  read_data_o,
  output logic        dirty_flag_o,
  output logic [15:0] pointer_now_o,
  output logic [31:0] read_txn_count_o,
  output logic [31:0] write_txn_count_o,
  output logic [31:0] bytes_written_count_o,
  output logic [31:0] bytes_read_count_o
);
  import smcs_pkg::*;

  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic q_empty;
  logic pop;
  cmd_t pop_cmd;

  smcs_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .op_i       (op_i),
    .data_in_i  (data_in_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .push_cmd_o (push_cmd)
  );

  smcs_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .pop_i      (pop),
    .pop_cmd_o  (pop_cmd),
    .empty_o    (q_empty)
  );

  smcs_back #(
    .ADDR_BITS (ADDR_BITS)
  ) u_back (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_we_i              (cfg_we_i),
    .cfg_idx_i             (cfg_idx_i),
    .cfg_data_i            (cfg_data_i),
    .q_empty_i             (q_empty),
    .q_cmd_i               (pop_cmd),
    .pop_o                 (pop),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .read_data_o           (read_data_o),
    .dirty_flag_o          (dirty_flag_o),
    .pointer_now_o         (pointer_now_o),
    .read_txn_count_o      (read_txn_count_o),
    .write_txn_count_o     (write_txn_count_o),
    .bytes_written_count_o (bytes_written_count_o),
    .bytes_read_count_o    (bytes_read_count_o)
  );

endmodule

`default_nettype wire

>>> sim/serial_memory_card_slave_tb.sv
// Self-checking testbench for serial_memory_card_slave: directed table, then random
// transaction bursts under several idle/stall mixes, checked by an in-bench card model.
// Depends on smcs_pkg and the serial_memory_card_slave RTL.
`timescale 1ns / 1ps

module serial_memory_card_slave_tb;
  import smcs_pkg::*;

  localparam logic [2:0] OP_UNUSED = 3'd7;

  typedef struct packed {
    logic [7:0]  rd;
    logic        dirty;
    logic [15:0] ptr;
    logic [31:0] rd_txns;
    logic [31:0] wr_txns;
    logic [31:0] bytes_wr;
    logic [31:0] bytes_rd;
  } card_resp_t;

  typedef struct {
    bit         is_cfg;
    logic       cfg_idx;
    logic [2:0] op;
    logic [7:0] din;
    bit         typed;
    card_resp_t want;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [4:0]  cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [2:0]  op_i;
  logic [7:0]  data_in_i;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  read_data_o;
  logic        dirty_flag_o;
  logic [15:0] pointer_now_o;
  logic [31:0] read_txn_count_o;
  logic [31:0] write_txn_count_o;
  logic [31:0] bytes_written_count_o;
  logic [31:0] bytes_read_count_o;

  serial_memory_card_slave dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_we_i              (cfg_we_i),
    .cfg_idx_i             (cfg_idx_i),
    .cfg_data_i            (cfg_data_i),
    .in_valid_i            (in_valid_i),
    .in_stall_o            (in_stall_o),
    .op_i                  (op_i),
    .data_in_i             (data_in_i),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .read_data_o           (read_data_o),
    .dirty_flag_o          (dirty_flag_o),
    .pointer_now_o         (pointer_now_o),
    .read_txn_count_o      (read_txn_count_o),
    .write_txn_count_o     (write_txn_count_o),
    .bytes_written_count_o (bytes_written_count_o),
    .bytes_read_count_o    (bytes_read_count_o)
  );

  always #5 clk_i = ~clk_i;

  // card model state
  logic [7:0]  m_mem [0:65535];
  bit          m_written [0:65535];
  logic [15:0] m_ptr;
  logic [7:0]  m_staged_hi;
  txn_e        m_txn;
  phase_e      m_phase;
  logic        m_dirty;
  logic [31:0] m_rd_txns;
  logic [31:0] m_wr_txns;
  logic [31:0] m_bytes_wr;
  logic [31:0] m_bytes_rd;
  logic        m_attached;
  logic [4:0]  m_size_log2;

  card_resp_t  resp_due_q [$];
  logic [15:0] stored_addr_q [$];
  dir_row_t    dir_rows [$];
  logic [4:0]  size_plan [0:7];
  int          src_idle_pct;
  int          sink_stall_pct;
  int          words_sent;
  int          fail_count;

  function automatic logic [15:0] ptr_mask();
    logic [4:0]  lg;
    logic [16:0] full;
    lg = m_size_log2;
    if (lg < SIZE_LOG2_MIN) lg = SIZE_LOG2_MIN;
    if (lg > PTR_W) lg = 5'(PTR_W);
    full = (17'd1 << lg) - 17'd1;
    return m_attached ? full[15:0] : 16'h0000;
  endfunction

  // closing a write that only got its high byte commits that byte
  function automatic void close_txn();
    if (m_txn == TXN_WRITE && m_phase == PH_LOW) m_ptr = {m_staged_hi, 8'h00} & ptr_mask();
    m_txn = TXN_IDLE;
    m_phase = PH_HIGH;
  endfunction

  task automatic card_model_step(input logic [2:0] op, input logic [7:0] din,
                                 output card_resp_t resp, output bit ignored);
    logic [15:0] mask;
    logic [7:0]  rd;
    mask = ptr_mask();
    rd = 8'h00;
    ignored = 1'b0;
    case (op)
      OP_START_WR, OP_START_RD: begin
        if (m_txn != TXN_IDLE) close_txn();
        m_txn = (op == OP_START_RD) ? TXN_READ : TXN_WRITE;
        m_phase = PH_HIGH;
        if (op == OP_START_RD) m_rd_txns++;
        else m_wr_txns++;
      end
      OP_RECV: begin
        if (m_txn != TXN_WRITE) begin
          ignored = 1'b1;
        end else if (m_phase == PH_HIGH) begin
          m_staged_hi = din;
          m_phase = PH_LOW;
        end else if (m_phase == PH_LOW) begin
          m_ptr = {m_staged_hi, din} & mask;
          m_phase = PH_DATA;
        end else if (m_attached) begin
          m_mem[m_ptr] = din;
          m_written[m_ptr] = 1'b1;
          stored_addr_q.push_back(m_ptr);
          if (stored_addr_q.size() > 256) void'(stored_addr_q.pop_front());
          m_ptr = (m_ptr + 16'd1) & mask;
          m_dirty = 1'b1;
          m_bytes_wr++;
        end
      end
      OP_XMIT: begin
        if (!m_attached) begin
          rd = DETACHED_BYTE;
        end else begin
          rd = m_mem[m_ptr];
          m_ptr = (m_ptr + 16'd1) & mask;
          m_bytes_rd++;
        end
      end
      OP_REWIND: begin
        if (m_attached) begin
          m_ptr = (m_ptr - 16'd1) & mask;
          if (m_bytes_rd != 32'd0) m_bytes_rd--;
        end
      end
      OP_STOP: close_txn();
      OP_CLR_DIRTY: m_dirty = 1'b0;
      default: ignored = 1'b1;
    endcase
    resp = {rd, m_dirty, m_ptr, m_rd_txns, m_wr_txns, m_bytes_wr, m_bytes_rd};
  endtask

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_word(input logic [2:0] op, input logic [7:0] din);
    card_resp_t resp;
    bit         ignored;
    // never read a card location that was not written
    if (op == OP_XMIT && m_attached && !m_written[m_ptr])
      op = ($urandom_range(1) != 0) ? OP_REWIND : OP_CLR_DIRTY;
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= op;
    data_in_i <= din;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    card_model_step(op, din, resp, ignored);
    resp_due_q.push_back(resp);
    if (!ignored) words_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (resp_due_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [4:0] val);
    drain_results();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    if (idx == CFG_ATTACHED) m_attached = val[0];
    else m_size_log2 = val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_burst();
    logic [31:0] rnd;
    logic [15:0] addr;
    int          kind;
    int          n;
    kind = $urandom_range(99);
    rnd = $urandom;
    addr = rnd[0] ? rnd[31:16] : {10'd0, rnd[21:16]};
    n = $urandom_range(8, 1);
    if (kind < 70) begin
      // load the pointer, then either store a run of bytes or read a run back
      if (kind >= 35 && stored_addr_q.size() != 0)
        addr = stored_addr_q[$urandom_range(stored_addr_q.size() - 1)];
      send_word(OP_START_WR, 8'($urandom_range(255)));
      send_word(OP_RECV, addr[15:8]);
      send_word(OP_RECV, addr[7:0]);
      if (kind >= 35 && stored_addr_q.size() != 0) begin
        send_word(OP_START_RD, 8'($urandom_range(255)));
        repeat (n) send_word(($urandom_range(99) < 15) ? OP_REWIND : OP_XMIT,
                             8'($urandom_range(255)));
      end else begin
        repeat (n) send_word(OP_RECV, 8'($urandom_range(255)));
      end
      if ($urandom_range(99) < 70) send_word(OP_STOP, 8'($urandom_range(255)));
    end else if (kind < 80) begin
      // pointer load cut short after the high byte
      send_word(OP_START_WR, 8'($urandom_range(255)));
      send_word(OP_RECV, addr[15:8]);
      case ($urandom_range(2))
        0: send_word(OP_STOP, 8'($urandom_range(255)));
        1: send_word(OP_START_RD, 8'($urandom_range(255)));
        default: send_word(OP_START_WR, 8'($urandom_range(255)));
      endcase
      repeat ($urandom_range(3, 1)) send_word(OP_XMIT, 8'($urandom_range(255)));
    end else begin
      repeat ($urandom_range(6, 1)) send_word(3'($urandom_range(7)), 8'($urandom_range(255)));
    end
  endtask

  function automatic void add_word(input logic [2:0] op, input logic [7:0] din);
    dir_row_t row;
    row.is_cfg = 1'b0;
    row.cfg_idx = 1'b0;
    row.op = op;
    row.din = din;
    row.typed = 1'b0;
    row.want = '0;
    dir_rows.push_back(row);
  endfunction

  function automatic void add_checked(input logic [2:0] op, input logic [7:0] din,
                                      input card_resp_t want);
    add_word(op, din);
    dir_rows[dir_rows.size() - 1].typed = 1'b1;
    dir_rows[dir_rows.size() - 1].want = want;
  endfunction

  function automatic void add_cfg(input logic idx, input logic [4:0] val);
    add_word(OP_UNUSED, {3'd0, val});
    dir_rows[dir_rows.size() - 1].is_cfg = 1'b1;
    dir_rows[dir_rows.size() - 1].cfg_idx = idx;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      if (fail_count < 10) $display("mismatch on %0s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(negedge clk_i) out_stall_i <= ($urandom_range(99) < sink_stall_pct);

  always @(posedge clk_i) begin : resp_check
    card_resp_t want;
    card_resp_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {read_data_o, dirty_flag_o, pointer_now_o, read_txn_count_o, write_txn_count_o,
             bytes_written_count_o, bytes_read_count_o};
      if (resp_due_q.size() == 0) begin
        if (fail_count < 10) $display("result word with nothing expected: %h", got);
        fail_count++;
      end else begin
        want = resp_due_q.pop_front();
        check_field("read_data", 32'(want.rd), 32'(got.rd));
        check_field("dirty_flag", 32'(want.dirty), 32'(got.dirty));
        check_field("pointer_now", 32'(want.ptr), 32'(got.ptr));
        check_field("read_txn_count", want.rd_txns, got.rd_txns);
        check_field("write_txn_count", want.wr_txns, got.wr_txns);
        check_field("bytes_written_count", want.bytes_wr, got.bytes_wr);
        check_field("bytes_read_count", want.bytes_rd, got.bytes_rd);
      end
    end
  end

  initial begin : stimulus
    logic [3:0] pad_bits;
    int         target;
    int         midway;
    bit         paused;
    int         waited;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = 1'b0;
    cfg_data_i = 5'd0;
    in_valid_i = 1'b0;
    op_i = 3'd0;
    data_in_i = 8'd0;
    src_idle_pct = 0;
    sink_stall_pct = 0;
    words_sent = 0;
    fail_count = 0;
    m_ptr = 16'h0000;
    m_staged_hi = 8'h00;
    m_txn = TXN_IDLE;
    m_phase = PH_HIGH;
    m_dirty = 1'b0;
    m_rd_txns = 32'd0;
    m_wr_txns = 32'd0;
    m_bytes_wr = 32'd0;
    m_bytes_rd = 32'd0;
    m_attached = 1'b0;
    m_size_log2 = SIZE_LOG2_RESET;
    // size 0 and 31 lie outside the legal range and must clamp
    size_plan = '{5'd16, 5'd4, 5'd0, 5'd31, 5'd9, 5'd8, 5'd2, 5'd16};

    // detached card straight out of reset
    add_checked(OP_XMIT, 8'h00, {DETACHED_BYTE, 1'b0, 16'h0000, 32'd0, 32'd0, 32'd0, 32'd0});
    add_checked(OP_START_WR, 8'h00, {8'h00, 1'b0, 16'h0000, 32'd0, 32'd1, 32'd0, 32'd0});
    add_word(OP_RECV, 8'hFF);
    add_word(OP_RECV, 8'hFF);
    add_word(OP_RECV, 8'hA5);
    add_word(OP_REWIND, 8'h00);
    add_word(OP_UNUSED, 8'hFF);
    add_cfg(CFG_ATTACHED, 5'd1);
    // start over an open write, store across the top of memory
    add_word(OP_START_WR, 8'h00);
    add_word(OP_RECV, 8'hFF);
    add_word(OP_RECV, 8'hFF);
    add_word(OP_RECV, 8'h00);
    add_word(OP_RECV, 8'hFF);
    add_word(OP_START_RD, 8'h00);
    add_word(OP_RECV, 8'h77);
    // rewind with nothing read yet, then wrap below zero
    add_word(OP_REWIND, 8'h00);
    add_word(OP_REWIND, 8'h00);
    add_word(OP_XMIT, 8'h00);
    add_word(OP_XMIT, 8'h00);
    add_word(OP_CLR_DIRTY, 8'h00);
    add_word(OP_START_WR, 8'h00);
    add_word(OP_RECV, 8'h81);
    add_word(OP_STOP, 8'h00);
    add_word(OP_START_WR, 8'h00);
    add_word(OP_RECV, 8'hFF);
    add_word(OP_RECV, 8'hFF);
    // shrink the card while the pointer sits above the new size
    add_cfg(CFG_SIZE_LOG2, 5'd0);
    add_word(OP_XMIT, 8'h00);

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        write_reg(dir_rows[i].cfg_idx, dir_rows[i].din[4:0]);
      end else begin
        send_word(dir_rows[i].op, dir_rows[i].din);
        if (dir_rows[i].typed) resp_due_q[resp_due_q.size() - 1] = dir_rows[i].want;
      end
    end

    for (int ph = 0; ph < 8; ph++) begin
      pad_bits = 4'($urandom_range(15));
      write_reg(CFG_ATTACHED, {pad_bits, ph != 4});
      write_reg(CFG_SIZE_LOG2, size_plan[ph]);
      case (ph % 4)
        0: begin
          src_idle_pct = 0;
          sink_stall_pct = 0;
        end
        1: begin
          src_idle_pct = 45;
          sink_stall_pct = 0;
        end
        2: begin
          src_idle_pct = 0;
          sink_stall_pct = 45;
        end
        default: begin
          src_idle_pct = 29;
          sink_stall_pct = 29;
        end
      endcase
      target = words_sent + 250;
      midway = words_sent + 125;
      paused = 1'b0;
      while (words_sent < target) begin
        random_burst();
        // hold the sender off until every word has come back
        if ((!paused && words_sent >= midway) || $urandom_range(39) == 0) begin
          drain_results();
          paused = 1'b1;
        end
      end
    end

    in_valid_i <= 1'b0;
    waited = 0;
    while (resp_due_q.size() != 0 && waited < 20000) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (20) @(negedge clk_i);
    if (resp_due_q.size() != 0) begin
      $display("%0d result words never arrived", resp_due_q.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("serial_memory_card_slave regression: pass");
    end else begin
      $display("serial_memory_card_slave regression: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("timeout waiting on the block");
    $display("serial_memory_card_slave regression: fail");
    $finish;
  end

endmodule

>>> serial_memory_card_slave.f
rtl/smcs_pkg.sv
rtl/smcs_queue.sv
rtl/smcs_front.sv
rtl/smcs_back.sv
rtl/serial_memory_card_slave.sv
sim/serial_memory_card_slave_tb.sv
